// File: rtl/harmonic_oscillator_bank_square_assert.svh
// Assertion macros for the harmonic oscillator bank.
// Included by the top level; depends on nothing else.
`ifndef HARMONIC_OSCILLATOR_BANK_SQUARE_ASSERT_SVH
`define HARMONIC_OSCILLATOR_BANK_SQUARE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define HOBSQ_ASSERT_IMP(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("hobsq assertion failed");
// Next-cycle implication, checked outside reset.
`define HOBSQ_ASSERT_NXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("hobsq assertion failed");
`else
`define HOBSQ_ASSERT_IMP(name, ck, rn, ante, cons)
`define HOBSQ_ASSERT_NXT(name, ck, rn, ante, cons)
`endif
`endif

// File: rtl/hobsq_pkg.sv
// Shared constants and types for the harmonic oscillator bank.
// Used by the divider, the oscillator cell and the top level.
`default_nettype none
package hobsq_pkg;

  // Bank size and fixed-point formats.
  localparam int OSC_N     = 6;
  localparam int FRAC_BITS = 30;
  localparam int STATE_W   = 32;
  localparam int START_W   = 31;
  localparam int IDX_W     = 3;
  localparam int SAMPLE_W  = 16;
  localparam int Q15_SHIFT = 15;

  // Mix term: |new| * 2^15 divided by the odd harmonic number.
  localparam int MAG_W    = STATE_W + Q15_SHIFT;
  localparam int TERM_W   = MAG_W + 1;
  localparam int DIV_STEP = 8;
  localparam int DIV_CYC  = (MAG_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_W    = DIV_CYC * DIV_STEP;
  localparam int D_W      = $clog2(2 * OSC_N);

  // Mix sum and the scaled result before saturation.
  localparam int SUM_W = TERM_W + $clog2(OSC_N) + 1;
  localparam int MIX_W = SUM_W - FRAC_BITS;

  // Sequencer counter covers both the divider and the sum chain.
  localparam int CNT_MAX = (OSC_N > DIV_CYC) ? OSC_N : DIV_CYC;
  localparam int CNT_W   = $clog2(CNT_MAX);

  // Input action codes.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Per-phase strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic mul_en;
    logic upd_en;
    logic div_en;
    logic term_en;
  } hobsq_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/hobsq_div.sv
// Serial divider of |new|*2^15 by a small odd divisor, DIV_STEP bits per step.
// Depends on hobsq_pkg.
`default_nettype none
module hobsq_div (
  input  wire logic                          clk,
  input  wire logic                          start,
  input  wire logic                          step,
  input  wire logic [hobsq_pkg::STATE_W-1:0] mag,
  input  wire logic [hobsq_pkg::D_W-1:0]     divisor,
  output logic      [hobsq_pkg::MAG_W-1:0]   quot
);

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  logic [hobsq_pkg::DVD_W-1:0] dvd_r, dvd_nxt, dvd_step;
  logic [hobsq_pkg::D_W-1:0]   rem_r, rem_nxt, rem_step;

  // One restoring step per dividend bit, DIV_STEP bits in this cycle.
  always_comb begin
    logic [hobsq_pkg::DVD_W-1:0] d_v;
    logic [hobsq_pkg::D_W:0]     r_v;
    logic [hobsq_pkg::D_W-1:0]   rem_v;
    d_v   = dvd_r;
    rem_v = rem_r;
    for (int i = 0; i < hobsq_pkg::DIV_STEP; i++) begin
      r_v = {rem_v, d_v[hobsq_pkg::DVD_W-1]};
      d_v = {d_v[hobsq_pkg::DVD_W-2:0], 1'b0};
      if (r_v >= {1'b0, divisor}) begin
        r_v    = r_v - {1'b0, divisor};
        d_v[0] = 1'b1;
      end
      rem_v = r_v[hobsq_pkg::D_W-1:0];
    end
    dvd_step = d_v;
    rem_step = rem_v;
  end

  // Load on start, advance on step, otherwise hold.
  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (start) begin
      dvd_nxt = hobsq_pkg::DVD_W'({mag, {hobsq_pkg::Q15_SHIFT{1'b0}}});
      rem_nxt = '0;
    end else if (step) begin
      dvd_nxt = dvd_step;
      rem_nxt = rem_step;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign quot = dvd_r[hobsq_pkg::MAG_W-1:0];

endmodule
`default_nettype wire

// File: rtl/hobsq_cell.sv
// One oscillator cell: coefficient and state, update, mix term and a stage of
// the partial-sum chain. Depends on hobsq_pkg and hobsq_div.
`default_nettype none
module hobsq_cell (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire hobsq_pkg::hobsq_ctrl_t               ctrl,
  input  wire logic [hobsq_pkg::D_W-1:0]            divisor,
  input  wire logic                                 coef_we,
  input  wire logic signed [hobsq_pkg::STATE_W-1:0] coef_wdata,
  input  wire logic                                 load_we,
  input  wire logic signed [hobsq_pkg::START_W-1:0] load_value,
  input  wire logic signed [hobsq_pkg::SUM_W-1:0]   psum_in,
  output logic      signed [hobsq_pkg::SUM_W-1:0]   psum_out
);

  localparam int PROD_W = 2 * hobsq_pkg::STATE_W;

  localparam logic signed [hobsq_pkg::STATE_W-1:0] SAT_MAX =
    {1'b0, {(hobsq_pkg::STATE_W-1){1'b1}}};
  localparam logic signed [hobsq_pkg::STATE_W-1:0] SAT_MIN =
    {1'b1, {(hobsq_pkg::STATE_W-1){1'b0}}};

  logic signed [hobsq_pkg::STATE_W-1:0] coef_r, coef_nxt;
  logic signed [hobsq_pkg::STATE_W-1:0] cur_r, cur_nxt;
  logic signed [hobsq_pkg::STATE_W-1:0] prev_r, prev_nxt;
  logic signed [PROD_W-1:0]             prod_r;
  logic signed [PROD_W:0]               diff_w;
  logic                                 ovf_w;
  logic signed [hobsq_pkg::STATE_W-1:0] nv_w;
  logic        [hobsq_pkg::STATE_W-1:0] mag_w;
  logic                                 neg_r;
  logic        [hobsq_pkg::MAG_W-1:0]   quot_w;
  logic signed [hobsq_pkg::TERM_W-1:0]  term_r, term_nxt;
  logic signed [hobsq_pkg::SUM_W-1:0]   psum_r;

  // Floor-scaled product minus previous, saturated to the state range.
  assign diff_w = (PROD_W+1)'(prod_r >>> hobsq_pkg::FRAC_BITS) - (PROD_W+1)'(prev_r);
  assign ovf_w  = diff_w[PROD_W:hobsq_pkg::STATE_W-1] !=
                  {(PROD_W-hobsq_pkg::STATE_W+2){diff_w[PROD_W]}};
  assign nv_w   = ovf_w ? (diff_w[PROD_W] ? SAT_MIN : SAT_MAX)
                        : diff_w[hobsq_pkg::STATE_W-1:0];
  assign mag_w  = nv_w[hobsq_pkg::STATE_W-1] ? (~nv_w + 1'b1) : nv_w;

  // Architectural state: coefficient write, seed load or a tick update.
  always_comb begin
    coef_nxt = coef_r;
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    if (coef_we) begin
      coef_nxt = coef_wdata;
    end
    if (load_we) begin
      cur_nxt  = hobsq_pkg::STATE_W'(load_value);
      prev_nxt = '0;
    end else if (ctrl.upd_en) begin
      cur_nxt  = nv_w;
      prev_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      cur_r  <= '0;
      prev_r <= '0;
    end else begin
      coef_r <= coef_nxt;
      cur_r  <= cur_nxt;
      prev_r <= prev_nxt;
    end
  end

  // Registered product, sign of the new value for the term.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(coef_r) * PROD_W'(cur_r);
    end
    if (ctrl.upd_en) begin
      neg_r <= nv_w[hobsq_pkg::STATE_W-1];
    end
  end

  hobsq_div u_div (
    .clk     (clk),
    .start   (ctrl.upd_en),
    .step    (ctrl.div_en),
    .mag     (mag_w),
    .divisor (divisor),
    .quot    (quot_w)
  );

  // Signed mix term, truncated toward zero.
  always_comb begin
    term_nxt = term_r;
    if (ctrl.term_en) begin
      term_nxt = neg_r ? -hobsq_pkg::TERM_W'(quot_w) : hobsq_pkg::TERM_W'(quot_w);
    end
  end

  // Partial sum moves one cell down the chain every cycle.
  always_ff @(posedge clk) begin
    term_r <= term_nxt;
    psum_r <= psum_in + hobsq_pkg::SUM_W'(term_r);
  end

  assign psum_out = psum_r;

endmodule
`default_nettype wire

// File: rtl/harmonic_oscillator_bank_square.sv
// A tick's result is registered at the output once the sequencer has run
// its phases; a load takes effect in the next cycle. A new transaction is
// taken only in idle, so ticks do not overlap; the pace is set by the
// serial divider in each cell and the partial-sum chain across the cells.
// Reset (synchronous, active low) clears coefficients, oscillator state,
// the sequencer and the output valid.
`default_nettype none
`include "harmonic_oscillator_bank_square_assert.svh"
module harmonic_oscillator_bank_square (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic        [hobsq_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic        [hobsq_pkg::STATE_W-1:0]  cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_action,
  input  wire logic        [hobsq_pkg::IDX_W-1:0]    in_osc_index,
  input  wire logic signed [hobsq_pkg::START_W-1:0]  in_start_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [hobsq_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                       out_clipped
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_TERM = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic signed [hobsq_pkg::SAMPLE_W-1:0] SMP_MAX =
    {1'b0, {(hobsq_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [hobsq_pkg::SAMPLE_W-1:0] SMP_MIN =
    {1'b1, {(hobsq_pkg::SAMPLE_W-1){1'b0}}};

  logic [2:0]                   state_r, state_nxt;
  logic [hobsq_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  hobsq_pkg::hobsq_ctrl_t       ctrl;
  logic                         in_fire;
  logic                         out_load;

  logic signed [hobsq_pkg::SUM_W-1:0]    psum_w [hobsq_pkg::OSC_N+1];
  logic signed [hobsq_pkg::SUM_W-1:0]    sum_w;
  logic                                  rnd_w;
  logic signed [hobsq_pkg::MIX_W-1:0]    mix_w;
  logic                                  clip_w;
  logic signed [hobsq_pkg::SAMPLE_W-1:0] smp_w;

  logic                                  out_valid_r, out_valid_nxt;
  logic signed [hobsq_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                  out_clipped_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // Tick sequencer: multiply, update, divide, form terms, let the sum settle, load the output.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_action == hobsq_pkg::ACT_TICK) begin
          ctrl.mul_en = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        ctrl.upd_en = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div_en = 1'b1;
        if (cnt_r == hobsq_pkg::CNT_W'(hobsq_pkg::DIV_CYC - 1)) begin
          state_nxt = ST_TERM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TERM: begin
        ctrl.term_en = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        if (cnt_r == hobsq_pkg::CNT_W'(hobsq_pkg::OSC_N - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Row of oscillator cells; the partial sum enters at cell 0.
  assign psum_w[0] = '0;

  for (genvar k = 0; k < hobsq_pkg::OSC_N; k++) begin : g_cell
    hobsq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .divisor    (hobsq_pkg::D_W'(2 * k + 1)),
      .coef_we    (cfg_we && (32'(cfg_index) == 32'(k))),
      .coef_wdata (cfg_data),
      .load_we    (in_fire && in_action == hobsq_pkg::ACT_LOAD &&
                   (32'(in_osc_index) == 32'(k))),
      .load_value (in_start_value),
      .psum_in    (psum_w[k]),
      .psum_out   (psum_w[k+1])
    );
  end

  // Scale the sum to Q15 with truncation toward zero, then saturate.
  assign sum_w  = psum_w[hobsq_pkg::OSC_N];
  assign rnd_w  = sum_w[hobsq_pkg::SUM_W-1] && (|sum_w[hobsq_pkg::FRAC_BITS-1:0]);
  assign mix_w  = hobsq_pkg::MIX_W'(sum_w >>> hobsq_pkg::FRAC_BITS) +
                  hobsq_pkg::MIX_W'(rnd_w);
  assign clip_w = mix_w[hobsq_pkg::MIX_W-1:hobsq_pkg::SAMPLE_W-1] !=
                  {(hobsq_pkg::MIX_W-hobsq_pkg::SAMPLE_W+1){mix_w[hobsq_pkg::MIX_W-1]}};
  assign smp_w  = clip_w ? (mix_w[hobsq_pkg::MIX_W-1] ? SMP_MIN : SMP_MAX)
                         : mix_w[hobsq_pkg::SAMPLE_W-1:0];

  // Output register holds a result until its transaction completes.
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r  <= smp_w;
      out_clipped_r <= clip_w;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

  // At most one phase strobe is active in any cycle.
  `HOBSQ_ASSERT_IMP(a_ctrl_onehot, clk, rst_n, 1'b1, $onehot0(ctrl))
  // A load never produces a result.
  `HOBSQ_ASSERT_NXT(a_load_no_result, clk, rst_n,
    in_fire && in_action == hobsq_pkg::ACT_LOAD && !out_valid_r, !out_valid_r)
  // After a tick is taken the input side is held off.
  `HOBSQ_ASSERT_NXT(a_tick_holds_input, clk, rst_n,
    in_fire && in_action == hobsq_pkg::ACT_TICK, in_stall)

endmodule
`default_nettype wire
